[rtl/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular double-ended queue unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

   localparam int WORD_W  = 32;
   localparam int DEPTH_W = 11;
   localparam int MODE_W  = 3;

   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 11'd1024;

   // Request mode codes. Codes five to seven change nothing and answer ok = 0.
   localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd4;

   localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      word_type          value;
   } req_type;

   typedef struct packed {
      logic     ok;
      word_type front_value;
      word_type back_value;
      logic     is_empty;
      logic     is_full;
   } rsp_type;

   // Per-operation status from the pointer logic.
   typedef struct packed {
      logic wr_en;
      logic ok;
      logic is_empty;
      logic is_full;
   } op_flags_type;

endpackage

`default_nettype wire

[rtl/cdq_mem.sv]
// ----------------------------------------------------------------------------
// cdq_mem
// Slot memory: one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire cdq_pkg::word_type wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr_a,
   input  wire logic [AW-1:0]    rd_addr_b,
   output cdq_pkg::word_type     rd_data_a,
   output cdq_pkg::word_type     rd_data_b
);

   cdq_pkg::word_type slot_mem [DEPTH];
   cdq_pkg::word_type rd_a_ff;
   cdq_pkg::word_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
   end

   // A read at the address being written returns the old word.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= slot_mem[rd_addr_a];
         rd_b_ff <= slot_mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

[rtl/cdq_ptr.sv]
// ----------------------------------------------------------------------------
// cdq_ptr
// Head index and occupancy registers, mode decode and slot address generation.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ptr #(
   parameter int MAX_DEPTH = 1024,
   parameter int AW        = 10,
   parameter int OW        = 11
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         step,
   input  wire logic [cdq_pkg::MODE_W-1:0]   mode,
   input  wire logic [cdq_pkg::DEPTH_W-1:0]  depth,
   output cdq_pkg::op_flags_type             flags,
   output logic [AW-1:0]                     wr_addr,
   output logic [AW-1:0]                     front_addr,
   output logic [AW-1:0]                     back_addr
);

   localparam int CMPW = (OW > cdq_pkg::DEPTH_W) ? OW : cdq_pkg::DEPTH_W;
   localparam int SW   = OW + 1;

   logic [AW-1:0]   head_ff, head_in;
   logic [OW-1:0]   occ_ff, occ_in;
   logic [CMPW-1:0] depth_ext;
   logic [CMPW-1:0] eff_depth;
   logic            full_now;
   logic            empty_now;
   logic [AW-1:0]   head_prev;
   logic [AW-1:0]   head_next;

   // Ring addition of an index and a count no larger than the ring size.
   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] idx,
                                              input logic [OW-1:0] cnt);
      logic [SW-1:0] sum;
      sum = SW'(idx) + SW'(cnt);
      if (sum >= SW'(MAX_DEPTH)) begin
         sum = sum - SW'(MAX_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   always_comb begin
      depth_ext = CMPW'(depth);
      if (depth_ext == '0) begin
         eff_depth = CMPW'(1);
      end else if (depth_ext > CMPW'(MAX_DEPTH)) begin
         eff_depth = CMPW'(MAX_DEPTH);
      end else begin
         eff_depth = depth_ext;
      end
   end

   assign full_now  = CMPW'(occ_ff) >= eff_depth;
   assign empty_now = occ_ff == '0;
   assign head_prev = (head_ff == '0) ? AW'(MAX_DEPTH - 1) : head_ff - AW'(1);
   assign head_next = (SW'(head_ff) + SW'(1) >= SW'(MAX_DEPTH)) ? '0 : head_ff + AW'(1);

   always_comb begin
      head_in     = head_ff;
      occ_in      = occ_ff;
      flags.wr_en = 1'b0;
      flags.ok    = 1'b0;
      wr_addr     = head_prev;
      case (mode)
         cdq_pkg::MODE_QUERY: begin
            flags.ok = 1'b1;
         end
         cdq_pkg::MODE_PUSH_FRONT: begin
            if (!full_now) begin
               head_in     = head_prev;
               occ_in      = occ_ff + OW'(1);
               flags.wr_en = 1'b1;
               flags.ok    = 1'b1;
            end
         end
         cdq_pkg::MODE_PUSH_BACK: begin
            wr_addr = ring_add(head_ff, occ_ff);
            if (!full_now) begin
               occ_in      = occ_ff + OW'(1);
               flags.wr_en = 1'b1;
               flags.ok    = 1'b1;
            end
         end
         cdq_pkg::MODE_POP_FRONT: begin
            if (!empty_now) begin
               head_in  = head_next;
               occ_in   = occ_ff - OW'(1);
               flags.ok = 1'b1;
            end
         end
         cdq_pkg::MODE_POP_BACK: begin
            if (!empty_now) begin
               occ_in   = occ_ff - OW'(1);
               flags.ok = 1'b1;
            end
         end
         default: begin
            flags.ok = 1'b0;
         end
      endcase
      flags.is_empty = occ_in == '0;
      flags.is_full  = CMPW'(occ_in) >= eff_depth;
      front_addr     = head_in;
      back_addr      = ring_add(head_in, (occ_in == '0) ? '0 : occ_in - OW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         occ_ff  <= '0;
      end else if (step) begin
         head_ff <= head_in;
         occ_ff  <= occ_in;
      end
   end

endmodule

`default_nettype wire

[rtl/circular_double_ended_queue_unit.sv]
// Path: a request beat is registered in stage one, then in the output register.
// Throughput: one request per cycle while the output is not stalled; head and
// occupancy update and the two slot reads of the memory are registered in the accept cycle.
// Reset clears head index, occupancy, stage one valid and output valid, and sets the
// depth register to 1024. The slot memory is not cleared; only words of written slots reach a result.
// ----------------------------------------------------------------------------
// circular_double_ended_queue_unit
// Ring-buffer deque of signed 32-bit words with push and pop at both ends.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_double_ended_queue_unit #(
   parameter int MAX_DEPTH = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire cdq_pkg::req_type            req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output cdq_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [cdq_pkg::DEPTH_W-1:0] csr_data
);

   // Slot index width and occupancy width (occupancy may equal MAX_DEPTH).
   localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int OW = $clog2(MAX_DEPTH + 1);

   // Depth register. Writes are taken at any time; software must write it only
   // while no beat is in flight, which the block itself does not enforce.
   logic [cdq_pkg::DEPTH_W-1:0] depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= cdq_pkg::DEPTH_RESET;
      end else if (csr_valid) begin
         depth_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;

   // Handshake. Stage one holds a beat whose slot reads are in flight; the
   // output register holds the finished result. Stage one only moves on when
   // the output register is free, and a new beat is taken whenever stage one
   // is empty or moving on, so the memory read registers are never
   // overwritten while a stalled beat still needs them.
   logic accept;
   logic out_free;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   // Pointer logic: decides the operation against the current state and
   // produces the write slot and the front and back slots after the update.
   cdq_pkg::op_flags_type op_flags;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         front_addr;
   logic [AW-1:0]         back_addr;

   cdq_ptr #(
      .MAX_DEPTH(MAX_DEPTH),
      .AW       (AW),
      .OW       (OW)
   ) u_ptr (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .mode      (req_data.mode),
      .depth     (depth_ff),
      .flags     (op_flags),
      .wr_addr   (wr_addr),
      .front_addr(front_addr),
      .back_addr (back_addr)
   );

   // Slot memory. The push is written in the same cycle as the reads of the
   // new front and back; the memory returns the old word on a collision, so
   // the pushed word is forwarded from stage one instead.
   cdq_pkg::word_type rd_front;
   cdq_pkg::word_type rd_back;
   logic              mem_wr_en;

   assign mem_wr_en = accept && op_flags.wr_en;

   cdq_mem #(
      .DEPTH(MAX_DEPTH),
      .AW   (AW)
   ) u_mem (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (req_data.value),
      .rd_en    (accept),
      .rd_addr_a(front_addr),
      .rd_addr_b(back_addr),
      .rd_data_a(rd_front),
      .rd_data_b(rd_back)
   );

   // Stage one payload: status flags, forwarding hits and the pushed word.
   cdq_pkg::op_flags_type s1_flags_ff;
   logic                  s1_fwd_front_ff;
   logic                  s1_fwd_back_ff;
   cdq_pkg::word_type     s1_word_ff;

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_flags_ff     <= op_flags;
         s1_fwd_front_ff <= mem_wr_en && (wr_addr == front_addr);
         s1_fwd_back_ff  <= mem_wr_en && (wr_addr == back_addr);
         s1_word_ff      <= req_data.value;
      end
   end

   // Result forming: an empty deque reports minus one at both ends.
   cdq_pkg::rsp_type rsp_data_in;
   cdq_pkg::rsp_type rsp_data_ff;

   always_comb begin
      rsp_data_in.ok       = s1_flags_ff.ok;
      rsp_data_in.is_empty = s1_flags_ff.is_empty;
      rsp_data_in.is_full  = s1_flags_ff.is_full;
      if (s1_flags_ff.is_empty) begin
         rsp_data_in.front_value = cdq_pkg::EMPTY_WORD;
         rsp_data_in.back_value  = cdq_pkg::EMPTY_WORD;
      end else begin
         rsp_data_in.front_value = s1_fwd_front_ff ? s1_word_ff : rd_front;
         rsp_data_in.back_value  = s1_fwd_back_ff  ? s1_word_ff : rd_back;
      end
      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // Every request beat taken occupies stage one in the next cycle.
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted beat did not reach stage one");

   // A beat stalled in stage one keeps its payload until it moves on.
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_word_ff)))
      else $error("stalled stage one beat was lost or changed");

   // The effective depth is at least one, so an empty deque is never full.
   a_empty_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.is_empty && rsp_data_ff.is_full))
      else $error("result reports empty and full together");

   // An empty result carries minus one at both ends.
   a_empty_words: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.is_empty) |->
         (rsp_data_ff.front_value == cdq_pkg::EMPTY_WORD &&
          rsp_data_ff.back_value == cdq_pkg::EMPTY_WORD))
      else $error("empty result carries stale words");
`endif

endmodule

`default_nettype wire
